[rtl/core/uart_dma_pkg.sv]
`timescale 1ns / 1ps

package uart_dma_pkg;

    // Defaults for the top-level parameters
    localparam int FIFO_DEPTH_DEF         = 64 * 1024;
    localparam int MAX_BYTES_PER_TICK_DEF = 64;
    localparam int CREDIT_FRAC_BITS_DEF   = 16;

    // Fixed field widths
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 32;
    localparam int BPT_W     = 22;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int CREDIT_INT_BITS = 8;

    typedef enum logic [1:0] {
        FUNC_BYTE   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_ARM    = 2'd2,
        FUNC_DISARM = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_BASE    = 2'd0,
        REG_BUFFER_LENGTH  = 2'd1,
        REG_BYTES_PER_TICK = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN
    } state_t;

endpackage

[rtl/core/uart_rx_paced_circular_dma_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Beat contents
// in        to block   in_valid/in_stall   func, byte_value
// out       from block out_valid/out_stall write_address, write_data, half_reached,
//                                          full_reached, line_idle, last
// cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A tick adds the rate to the credit, then splits off the whole bytes, then issues one
// FIFO memory read per cycle for each drained byte while the output does not stall;
// each read passes the read stage register, then the result register. The input side
// is stalled from the tick until the last read of that tick has been issued.
// The single read port of the byte FIFO memory sets the one-byte-per-cycle drain.
// Reset clears all control state; the FIFO memory is not cleared and holds no data
// until bytes are written. An output stall holds the result register and the read
// behind it; draining resumes when the stall drops. cfg_ready is always high.

module uart_rx_paced_circular_dma_unit #(
    parameter int FIFO_DEPTH         = uart_dma_pkg::FIFO_DEPTH_DEF,
    parameter int MAX_BYTES_PER_TICK = uart_dma_pkg::MAX_BYTES_PER_TICK_DEF,
    parameter int CREDIT_FRAC_BITS   = uart_dma_pkg::CREDIT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic [uart_dma_pkg::DATA_W-1:0]     byte_value,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [uart_dma_pkg::ADDR_W-1:0]     write_address,
    output logic [uart_dma_pkg::DATA_W-1:0]     write_data,
    output logic                                half_reached,
    output logic                                full_reached,
    output logic                                line_idle,
    output logic                                last,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uart_dma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uart_dma_pkg::CFG_DAT_W-1:0]  cfg_data
);

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int OCC_W  = PTR_W + 1;
    localparam int CW     = CREDIT_FRAC_BITS + uart_dma_pkg::CREDIT_INT_BITS;
    localparam int SUM_W  = ((CW > uart_dma_pkg::BPT_W) ? CW : uart_dma_pkg::BPT_W) + 1;
    localparam int N_W    = $clog2(MAX_BYTES_PER_TICK + 1);
    localparam int MIN_W  = (OCC_W > uart_dma_pkg::CREDIT_INT_BITS) ?
                            OCC_W : uart_dma_pkg::CREDIT_INT_BITS;
    localparam int IW     = uart_dma_pkg::CREDIT_INT_BITS;
    localparam logic [CW-1:0] CREDIT_MAX = {CW{1'b1}};

    // Control state
    uart_dma_pkg::state_t            state_reg, state_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]                occ_reg, occ_next;
    logic [uart_dma_pkg::LEN_W-1:0]  dma_count_reg, dma_count_next;
    logic [CW-1:0]                   credit_reg, credit_next;
    logic                            armed_reg, armed_next;
    logic [N_W-1:0]                  remain_reg, remain_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic                            out_valid_reg, out_valid_next;

    // Configuration
    logic [uart_dma_pkg::ADDR_W-1:0] base_reg;
    logic [uart_dma_pkg::LEN_W-1:0]  length_reg;
    logic [uart_dma_pkg::BPT_W-1:0]  bpt_reg;

    // Read stage and result register payload
    logic [uart_dma_pkg::DATA_W-1:0] mem_rdata_reg;
    logic [uart_dma_pkg::ADDR_W-1:0] pend_addr_reg;
    logic                            pend_half_reg, pend_full_reg, pend_idle_reg, pend_last_reg;
    logic [uart_dma_pkg::ADDR_W-1:0] write_address_reg;
    logic [uart_dma_pkg::DATA_W-1:0] write_data_reg;
    logic                            half_reg, full_reg, idle_reg, last_reg;

    logic [uart_dma_pkg::DATA_W-1:0] fifo_mem [FIFO_DEPTH];

    // Datapath helpers
    logic                            mem_we, mem_re;
    logic [PTR_W-1:0]                mem_waddr;
    logic [OCC_W-1:0]                wr_sum;
    logic [PTR_W-1:0]                wr_ptr;
    logic [OCC_W-1:0]                rd_inc;
    logic [PTR_W-1:0]                rd_ptr_wrap;
    logic [SUM_W-1:0]                credit_sum;
    logic [CW-1:0]                   credit_sat;
    logic [IW-1:0]                   credit_whole;
    logic [MIN_W-1:0]                n_a, n_b;
    logic [N_W-1:0]                  n_bytes;
    logic [uart_dma_pkg::LEN_W-1:0]  cnt_inc;
    logic                            half_hit, full_hit, last_hit, idle_hit;
    logic                            pend_take, issue;

    assign wr_sum = OCC_W'(rd_ptr_reg) + occ_reg;
    assign wr_ptr = (wr_sum >= OCC_W'(FIFO_DEPTH)) ?
                    PTR_W'(wr_sum - OCC_W'(FIFO_DEPTH)) : PTR_W'(wr_sum);
    assign rd_inc      = OCC_W'(rd_ptr_reg) + OCC_W'(1);
    assign rd_ptr_wrap = (rd_inc == OCC_W'(FIFO_DEPTH)) ? '0 : PTR_W'(rd_inc);

    assign credit_sum = SUM_W'(credit_reg) + SUM_W'(bpt_reg);
    assign credit_sat = (credit_sum > SUM_W'(CREDIT_MAX)) ? CREDIT_MAX : CW'(credit_sum);

    // n = min(whole credit, occupancy, cap)
    assign credit_whole = credit_reg[CW-1:CREDIT_FRAC_BITS];
    assign n_a     = (MIN_W'(credit_whole) < MIN_W'(occ_reg)) ?
                     MIN_W'(credit_whole) : MIN_W'(occ_reg);
    assign n_b     = (n_a < MIN_W'(MAX_BYTES_PER_TICK)) ? n_a : MIN_W'(MAX_BYTES_PER_TICK);
    assign n_bytes = N_W'(n_b);

    assign cnt_inc  = dma_count_reg + uart_dma_pkg::LEN_W'(1);
    assign half_hit = (cnt_inc == (length_reg >> 1));
    assign full_hit = (cnt_inc >= length_reg);
    assign last_hit = (remain_reg == N_W'(1));
    assign idle_hit = last_hit && (occ_reg == OCC_W'(1));

    assign pend_take = pend_valid_reg && (!out_valid_reg || !out_stall);
    assign issue     = (state_reg == uart_dma_pkg::ST_DRAIN) && (!pend_valid_reg || pend_take);

    always_comb
    begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        occ_next        = occ_reg;
        dma_count_next  = dma_count_reg;
        credit_next     = credit_reg;
        armed_next      = armed_reg;
        remain_next     = remain_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = wr_ptr;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_take)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            uart_dma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (uart_dma_pkg::func_t'(func))
                        uart_dma_pkg::FUNC_BYTE:
                        begin
                            if (armed_reg && (occ_reg < OCC_W'(FIFO_DEPTH)))
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + OCC_W'(1);
                                if (occ_reg == '0)
                                begin
                                    rd_ptr_next = '0;
                                    credit_next = '0;
                                    mem_waddr   = '0;
                                end
                            end
                        end
                        uart_dma_pkg::FUNC_TICK:
                        begin
                            if (armed_reg && (occ_reg != '0))
                            begin
                                credit_next = credit_sat;
                                state_next  = uart_dma_pkg::ST_CALC;
                            end
                        end
                        uart_dma_pkg::FUNC_ARM:
                        begin
                            if (!armed_reg)
                            begin
                                armed_next     = 1'b1;
                                dma_count_next = '0;
                                rd_ptr_next    = '0;
                                occ_next       = '0;
                                credit_next    = '0;
                            end
                        end
                        uart_dma_pkg::FUNC_DISARM:
                        begin
                            if (armed_reg)
                            begin
                                armed_next  = 1'b0;
                                rd_ptr_next = '0;
                                occ_next    = '0;
                                credit_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = uart_dma_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            uart_dma_pkg::ST_CALC:
            begin
                // whole bytes come off the integer part only
                credit_next = {credit_whole - IW'(n_bytes), credit_reg[CREDIT_FRAC_BITS-1:0]};
                remain_next = n_bytes;
                state_next  = (n_bytes == '0) ? uart_dma_pkg::ST_IDLE : uart_dma_pkg::ST_DRAIN;
            end
            uart_dma_pkg::ST_DRAIN:
            begin
                if (issue)
                begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    rd_ptr_next     = (occ_reg == OCC_W'(1)) ? '0 : rd_ptr_wrap;
                    occ_next        = occ_reg - OCC_W'(1);
                    dma_count_next  = full_hit ? '0 : cnt_inc;
                    remain_next     = remain_reg - N_W'(1);
                    if (last_hit)
                    begin
                        state_next = uart_dma_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = uart_dma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= uart_dma_pkg::ST_IDLE;
            rd_ptr_reg     <= '0;
            occ_reg        <= '0;
            dma_count_reg  <= '0;
            credit_reg     <= '0;
            armed_reg      <= 1'b0;
            remain_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            occ_reg        <= occ_next;
            dma_count_reg  <= dma_count_next;
            credit_reg     <= credit_next;
            armed_reg      <= armed_next;
            remain_reg     <= remain_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            length_reg <= '0;
            bpt_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (uart_dma_pkg::cfg_reg_t'(cfg_index))
                uart_dma_pkg::REG_BUFFER_BASE:    base_reg   <= cfg_data;
                uart_dma_pkg::REG_BUFFER_LENGTH:  length_reg <= cfg_data;
                uart_dma_pkg::REG_BYTES_PER_TICK: bpt_reg    <= cfg_data[uart_dma_pkg::BPT_W-1:0];
                default:                          base_reg   <= base_reg;
            endcase
        end
    end

    // Byte FIFO storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[mem_waddr] <= byte_value;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_addr_reg <= base_reg + dma_count_reg;
            pend_half_reg <= half_hit;
            pend_full_reg <= full_hit;
            pend_idle_reg <= idle_hit;
            pend_last_reg <= last_hit;
        end
        if (pend_take)
        begin
            write_address_reg <= pend_addr_reg;
            write_data_reg    <= mem_rdata_reg;
            half_reg          <= pend_half_reg;
            full_reg          <= pend_full_reg;
            idle_reg          <= pend_idle_reg;
            last_reg          <= pend_last_reg;
        end
    end

    assign in_stall      = (state_reg != uart_dma_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign half_reached  = half_reg;
    assign full_reached  = full_reg;
    assign line_idle     = idle_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(FIFO_DEPTH))
        else $error("fifo occupancy above depth");

    a_drain_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uart_dma_pkg::ST_DRAIN) |-> (remain_reg != '0) && (occ_reg != '0))
        else $error("drain with no bytes left");

    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_valid_reg && out_stall) |=> pend_valid_reg)
        else $error("pending read lost under stall");

    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_idle_reg) |-> pend_last_reg)
        else $error("line idle on a non-last beat");
`endif

endmodule

[tb/tb_uart_rx_paced_circular_dma_unit.sv]
`timescale 1ns / 1ps

module tb_uart_rx_paced_circular_dma_unit;

    localparam int FIFO_DEPTH    = uart_dma_pkg::FIFO_DEPTH_DEF;
    localparam int MAX_DRAIN     = uart_dma_pkg::MAX_BYTES_PER_TICK_DEF;
    localparam int FRAC          = uart_dma_pkg::CREDIT_FRAC_BITS_DEF;
    localparam int CREDIT_W      = FRAC + uart_dma_pkg::CREDIT_INT_BITS;
    localparam longint unsigned CREDIT_LIMIT = (longint'(1) << CREDIT_W) - 1;

    localparam int ADDR_W    = uart_dma_pkg::ADDR_W;
    localparam int LEN_W     = uart_dma_pkg::LEN_W;
    localparam int BPT_W     = uart_dma_pkg::BPT_W;
    localparam int DATA_W    = uart_dma_pkg::DATA_W;
    localparam int CFG_IDX_W = uart_dma_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = uart_dma_pkg::CFG_DAT_W;

    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 3000;
    localparam int RANDOM_ITEMS     = 60;
    localparam int MAX_REPORTS      = 100;

    // index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_INDEX = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic              half_reached;
        logic              full_reached;
        logic              line_idle;
        logic              last;
    } dma_write_t;

    class dma_scoreboard;
        logic [ADDR_W-1:0]   base_addr;
        logic [LEN_W-1:0]    buf_len;
        logic [BPT_W-1:0]    rate;
        logic [DATA_W-1:0]   fifo_mem [FIFO_DEPTH];
        int unsigned         rd_ptr;
        int unsigned         occupancy;
        logic [LEN_W-1:0]    wr_count;
        logic [CREDIT_W-1:0] credit;
        bit                  armed;
        dma_write_t          pending_writes [$];
        int                  errors;
        int                  reports;

        function new();
            base_addr    = '0;
            buf_len      = '0;
            rate         = '0;
            rd_ptr       = 0;
            occupancy    = 0;
            wr_count     = '0;
            credit       = '0;
            armed        = 1'b0;
            errors       = 0;
            reports      = 0;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                uart_dma_pkg::REG_BUFFER_BASE:    base_addr = data;
                uart_dma_pkg::REG_BUFFER_LENGTH:  buf_len   = data;
                uart_dma_pkg::REG_BYTES_PER_TICK: rate      = data[BPT_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 0 when the beat leaves the channel untouched.
        function bit note_input(uart_dma_pkg::func_t f, logic [DATA_W-1:0] b);
            longint unsigned sum;
            int unsigned     n;
            int unsigned     i;
            dma_write_t      w;
            case (f)
                uart_dma_pkg::FUNC_BYTE:
                begin
                    if (!armed || occupancy >= FIFO_DEPTH)
                        return 1'b0;
                    if (occupancy == 0)
                    begin
                        rd_ptr = 0;
                        credit = '0;
                    end
                    fifo_mem[(rd_ptr + occupancy) % FIFO_DEPTH] = b;
                    occupancy++;
                end
                uart_dma_pkg::FUNC_ARM, uart_dma_pkg::FUNC_DISARM:
                begin
                    if ((f == uart_dma_pkg::FUNC_ARM) == armed)
                        return 1'b0;
                    armed = (f == uart_dma_pkg::FUNC_ARM);
                    if (armed)
                        wr_count = '0;
                    rd_ptr    = 0;
                    occupancy = 0;
                    credit    = '0;
                end
                default:
                begin
                    if (!armed || occupancy == 0)
                        return 1'b0;
                    sum = longint'(credit) + longint'(rate);
                    if (sum > CREDIT_LIMIT)
                        sum = CREDIT_LIMIT;
                    credit = sum[CREDIT_W-1:0];
                    n = credit >> FRAC;
                    if (n > occupancy)
                        n = occupancy;
                    if (n > MAX_DRAIN)
                        n = MAX_DRAIN;
                    for (i = 0; i < n; i++)
                    begin
                        w.write_address = base_addr + wr_count;
                        w.write_data    = fifo_mem[rd_ptr];
                        rd_ptr          = (rd_ptr + 1) % FIFO_DEPTH;
                        occupancy--;
                        wr_count        = wr_count + 1;
                        w.half_reached  = (wr_count == (buf_len >> 1));
                        w.full_reached  = (wr_count >= buf_len);
                        if (w.full_reached)
                            wr_count = '0;
                        w.last      = (i + 1 == n);
                        w.line_idle = w.last && (occupancy == 0);
                        pending_writes.push_back(w);
                    end
                    credit = credit - CREDIT_W'(n << FRAC);
                    if (occupancy == 0)
                        rd_ptr = 0;
                end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, field, exp_v, act_v);
                end
            end
        endfunction

        function void check_result(dma_write_t got);
            dma_write_t want;
            if (pending_writes.size() == 0)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display({"%0t: unexpected write, expected none, ",
                              "actual address 0x%0h data 0x%0h"},
                             $time, got.write_address, got.write_data);
                end
                return;
            end
            want = pending_writes.pop_front();
            compare_field("write_address", want.write_address, got.write_address);
            compare_field("write_data", want.write_data, got.write_data);
            compare_field("half_reached", want.half_reached, got.half_reached);
            compare_field("full_reached", want.full_reached, got.full_reached);
            compare_field("line_idle", want.line_idle, got.line_idle);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    uart_dma_pkg::func_t  in_func = uart_dma_pkg::FUNC_BYTE;
    logic [DATA_W-1:0]    in_byte = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ADDR_W-1:0]    write_address;
    logic [DATA_W-1:0]    write_data;
    logic                 half_reached;
    logic                 full_reached;
    logic                 line_idle;
    logic                 last;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    dma_scoreboard sb;
    int unsigned   items_sent = 0;
    int            burst_left = 0;
    bit            pace_on = 1'b1;
    bit            long_hold_req = 1'b0;
    int            idle_cycles = 0;

    uart_rx_paced_circular_dma_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (in_func),
        .byte_value    (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .half_reached  (half_reached),
        .full_reached  (full_reached),
        .line_idle     (line_idle),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin : out_monitor
        dma_write_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.write_address = write_address;
            got.write_data    = write_data;
            got.half_reached  = half_reached;
            got.full_reached  = full_reached;
            got.line_idle     = line_idle;
            got.last          = last;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: stall pattern changes per segment; one long hold on request.
    initial
    begin : receiver
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 7) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input uart_dma_pkg::func_t f, input logic [DATA_W-1:0] b);
        in_valid <= 1'b1;
        in_func  <= f;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        void'(sb.note_input(f, b));
        items_sent++;
        if (pace_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // A tick that drains nothing still keeps the block busy in its calc state.
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] base_v, input logic [31:0] len_v,
                             input logic [31:0] rate_v);
        wait_idle();
        cfg_write(uart_dma_pkg::REG_BUFFER_BASE, base_v, 1'b1);
        cfg_write(uart_dma_pkg::REG_BUFFER_LENGTH, len_v, 1'b1);
        cfg_write(uart_dma_pkg::REG_BYTES_PER_TICK, rate_v, 1'b0);
    endtask

    task automatic directed_checks();
        wait_idle();
        cfg_write(REG_SPARE_INDEX, 32'hFFFF_FFFF, 1'b1);
        cfg_write(uart_dma_pkg::REG_BUFFER_BASE, 32'hFFFF_FFFE, 1'b1);
        cfg_write(uart_dma_pkg::REG_BUFFER_LENGTH, 32'd6, 1'b1);
        cfg_write(uart_dma_pkg::REG_BYTES_PER_TICK, 32'h0001_8000, 1'b0);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h00);
        send_beat(uart_dma_pkg::FUNC_DISARM, 8'hFF);
        send_beat(uart_dma_pkg::FUNC_ARM, 8'h00);
        send_beat(uart_dma_pkg::FUNC_ARM, 8'hFF);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'hFF);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h00);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'hFF);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'hA5);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h5A);
        // 1.5 bytes per tick: drains 1, 2, 1; address wraps past the top
        repeat (3) send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h3C);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'hC3);
        send_beat(uart_dma_pkg::FUNC_DISARM, 8'h00);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        send_beat(uart_dma_pkg::FUNC_ARM, 8'h00);

        // zero length wraps on every write; rate written with bits above the field
        configure(32'h0000_0000, 32'd0, 32'hFFFF_FFFF);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h81);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h7E);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h01);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);

        configure(32'h8000_0000, 32'd1, 32'h0002_0000);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h80);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h7F);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);

        // count left above a shortened length wraps on the next write
        configure(32'h0000_1000, 32'd100, 32'hFFFF_FFFF);
        repeat (10) send_beat(uart_dma_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        wait_idle();
        cfg_write(uart_dma_pkg::REG_BUFFER_LENGTH, 32'd4, 1'b0);
        send_beat(uart_dma_pkg::FUNC_BYTE, 8'h55);
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
    endtask

    // Keep the credit under one byte for a tick, then raise the rate so the next
    // tick is held to the per-tick cap with bytes left over.
    task automatic drain_cap_checks();
        configure($urandom(), 32'd1000, 32'h0000_8000);
        pace_on = 1'b0;
        send_beat(uart_dma_pkg::FUNC_DISARM, 8'h00);
        send_beat(uart_dma_pkg::FUNC_ARM, 8'h00);
        repeat (MAX_DRAIN + 2) send_beat(uart_dma_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        wait_idle();
        cfg_write(uart_dma_pkg::REG_BYTES_PER_TICK, 32'h003F_FFFF, 1'b0);
        repeat (2) send_beat(uart_dma_pkg::FUNC_TICK, 8'h00);
        send_beat(uart_dma_pkg::FUNC_DISARM, 8'h00);
        pace_on = 1'b1;
    endtask

    task automatic random_checks();
        int unsigned start_items;
        int unsigned phase;
        int unsigned groups;
        int unsigned g;
        int unsigned burst;
        logic [31:0] base_v;
        logic [31:0] len_v;
        logic [31:0] rate_v;
        start_items = items_sent;
        phase       = 0;
        while (items_sent - start_items < RANDOM_ITEMS || phase < 3)
        begin
            case ($urandom_range(0, 2))
                0: base_v = '0;
                1: base_v = 32'hFFFF_FFFF - $urandom_range(0, 64);
                default: base_v = $urandom();
            endcase
            case ($urandom_range(0, 6))
                0: len_v = 32'd0;
                1: len_v = 32'd1;
                2: len_v = 32'd2;
                3: len_v = $urandom_range(3, 40);
                4: len_v = 32'hFFFF_FFFF;
                5: len_v = $urandom_range(41, 300);
                default: len_v = $urandom();
            endcase
            case ($urandom_range(0, 5))
                0: rate_v = 32'd0;
                1: rate_v = 32'hFFFF_FFFF;
                2: rate_v = $urandom_range(1, 32'h0000_FFFF);
                3: rate_v = $urandom_range(32'h0001_0000, 32'h0004_0000);
                4: rate_v = 32'h0001_0000;
                default: rate_v = $urandom();
            endcase
            if (phase == 2)
                rate_v = 32'h003F_FFFF;
            configure(base_v, len_v, rate_v);
            pace_on = ($urandom_range(0, 3) != 0);
            if (phase == 2)
                long_hold_req = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_beat(uart_dma_pkg::FUNC_DISARM, 8'($urandom_range(0, 255)));
            send_beat(uart_dma_pkg::FUNC_ARM, 8'($urandom_range(0, 255)));
            groups = $urandom_range(2, 4);
            for (g = 0; g < groups; g++)
            begin
                if (phase != 2 && $urandom_range(0, 7) == 0)
                    send_beat(uart_dma_pkg::func_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)));
                else
                begin
                    burst = (phase == 2) ? $urandom_range(8, 20) : $urandom_range(1, 8);
                    repeat (burst)
                        send_beat(uart_dma_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 3))
                        send_beat(uart_dma_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
                end
                if (phase == 1 && g == 0)
                    wait_drained();
            end
            phase++;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        drain_cap_checks();
        random_checks();
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/uart_dma_pkg.sv
rtl/core/uart_rx_paced_circular_dma_unit.sv
tb/tb_uart_rx_paced_circular_dma_unit.sv
